// ===== hdl/index_v2_stream_parser_macros.svh =====
// Assertion helpers for the checker file.
`ifndef INDEX_V2_STREAM_PARSER_MACROS_SVH
`define INDEX_V2_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define IXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is low.
`define IXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ixp_pkg.sv =====
`default_nettype none

package ixp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FIXED,
    PH_NSHORT,
    PH_NLONG,
    PH_TERM,
    PH_SCAN,
    PH_PAD,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_FIELD  = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_SIG     = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_TRUNCATED   = 3'd3;
  localparam logic [2:0] ST_UNUSED      = 3'd4;
  localparam logic [2:0] ST_BAD_MODE    = 3'd5;
  localparam logic [2:0] ST_UNTERM      = 3'd6;

  localparam logic [31:0] SIGNATURE        = 32'h4449_5243;
  localparam logic [31:0] HDR_VERSION      = 32'd2;
  localparam logic [3:0]  HDR_VERSION_LAST = 4'd7;
  localparam logic [3:0]  HDR_SIG_LEN      = 4'd4;
  localparam logic [3:0]  HDR_LAST         = 4'd11;

  localparam logic [5:0] OFS_WORDS_END   = 6'd24;
  localparam logic [5:0] OFS_UNUSED_LAST = 6'd25;
  localparam logic [5:0] OFS_MODE_LAST   = 6'd27;
  localparam logic [5:0] OFS_IDS_START   = 6'd28;
  localparam logic [5:0] OFS_IDS_END     = 6'd60;
  localparam logic [5:0] FIXED_LAST      = 6'd61;

  localparam logic [3:0] FIELD_MODE  = 4'd6;
  localparam logic [3:0] FIELD_FLAGS = 4'd15;

  localparam logic [3:0] MODE_FILE   = 4'b1000;
  localparam logic [3:0] MODE_LINK   = 4'b1010;
  localparam logic [3:0] MODE_SUBMOD = 4'b1110;

  localparam logic [11:0] LONG_NAME = 12'hFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  field_index;
    logic [31:0] value;
    logic [3:0]  mode_class;
    logic [8:0]  perm_bits;
    logic        assume_valid;
    logic [1:0]  stage_num;
    logic [11:0] name_len;
    logic        extended_flag;
    logic [31:0] entry_number;
    logic [2:0]  status;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  header_offset;
    logic [5:0]  field_offset;
    logic [31:0] word_shift;
    logic [31:0] entries_expected;
    logic [31:0] entry_index;
    logic [11:0] name_remaining;
    logic [2:0]  entry_length_low;
    logic [2:0]  padding_left;
    logic [2:0]  pending_error;
  } state_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [1:0] pos;
    pos = 2'd3 - idx;
    return SIGNATURE[{pos, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ixp_step.sv =====
`default_nettype none

module ixp_step (
  input  wire ixp_pkg::state_t    st_i,
  input  wire ixp_pkg::in_word_t  in_i,
  output ixp_pkg::state_t         st_o,
  output ixp_pkg::out_word_t      res0_o,
  output ixp_pkg::out_word_t      res1_o,
  output logic [1:0]              n_res_o
);

  typedef enum logic [2:0] {
    SL_NONE,
    SL_WORD,
    SL_MODE,
    SL_FLAGS,
    SL_NAME,
    SL_END,
    SL_STAT,
    SL_STATN
  } slot_t;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] ws;
  logic [2:0]  ell_inc;
  logic [2:0]  pad_init;
  logic [2:0]  pad_dec;
  logic [11:0] name_dec;
  logic [31:0] idx_inc;
  logic [5:0]  o;
  logic        mode_ok;
  logic        word_ofs;

  logic [2:0]  pe;
  logic [2:0]  code;
  logic        nd;
  logic        fin;
  slot_t       slot0;
  slot_t       slot1;

  assign b        = in_i.byte_in;
  assign eof      = in_i.end_of_file;
  assign ws       = {st_i.word_shift[23:0], b};
  assign ell_inc  = st_i.entry_length_low + 3'd1;
  assign pad_init = 3'd0 - ell_inc;
  assign pad_dec  = st_i.padding_left - 3'd1;
  assign name_dec = st_i.name_remaining - 12'd1;
  assign idx_inc  = st_i.entry_index + 32'd1;
  assign o        = st_i.field_offset;
  assign mode_ok  = (ws[15:12] == ixp_pkg::MODE_FILE) || (ws[15:12] == ixp_pkg::MODE_LINK) ||
                    (ws[15:12] == ixp_pkg::MODE_SUBMOD);
  assign word_ofs = (o[1:0] == 2'b11) &&
                    ((o < ixp_pkg::OFS_WORDS_END) ||
                     ((o >= ixp_pkg::OFS_IDS_START) && (o < ixp_pkg::OFS_IDS_END)));

  // next state and result selection
  always_comb begin
    st_o  = st_i;
    pe    = st_i.pending_error;
    code  = ixp_pkg::ST_OK;
    nd    = 1'b0;
    fin   = 1'b0;
    slot0 = SL_NONE;
    slot1 = SL_NONE;
    unique case (st_i.phase)
      ixp_pkg::PH_HEADER: begin
        st_o.word_shift    = ws;
        st_o.header_offset = st_i.header_offset + 4'd1;
        if ((st_i.header_offset < ixp_pkg::HDR_SIG_LEN) &&
            (b != ixp_pkg::sig_byte(st_i.header_offset[1:0]))) begin
          slot0 = SL_STAT;
          code  = ixp_pkg::ST_BAD_SIG;
          st_o.phase = ixp_pkg::PH_DONE;
        end else begin
          if ((st_i.header_offset == ixp_pkg::HDR_VERSION_LAST) &&
              (ws != ixp_pkg::HDR_VERSION)) begin
            pe = ixp_pkg::ST_BAD_VERSION;
          end
          st_o.pending_error = pe;
          if (st_i.header_offset >= ixp_pkg::HDR_LAST) begin
            if (pe != ixp_pkg::ST_OK) begin
              slot0 = SL_STAT;
              code  = pe;
              st_o.phase = ixp_pkg::PH_DONE;
            end else begin
              st_o.entries_expected = ws;
              if (ws == 32'd0) begin
                slot0 = SL_STAT;
                code  = ixp_pkg::ST_OK;
                st_o.phase = ixp_pkg::PH_DONE;
              end else if (eof) begin
                slot0 = SL_STAT;
                code  = ixp_pkg::ST_TRUNCATED;
                st_o.phase = ixp_pkg::PH_DONE;
              end else begin
                st_o.phase            = ixp_pkg::PH_FIXED;
                st_o.field_offset     = 6'd0;
                st_o.entry_length_low = 3'd0;
              end
            end
          end else if (eof) begin
            slot0 = SL_STAT;
            code  = ixp_pkg::ST_BAD_SIG;
            st_o.phase = ixp_pkg::PH_DONE;
          end
        end
      end
      ixp_pkg::PH_FIXED: begin
        st_o.word_shift       = ws;
        st_o.entry_length_low = ell_inc;
        if (word_ofs) begin
          slot0 = SL_WORD;
        end else if (o == ixp_pkg::OFS_UNUSED_LAST) begin
          if ((ws[15:0] != 16'd0) && (pe == ixp_pkg::ST_OK)) begin
            pe = ixp_pkg::ST_UNUSED;
          end
        end else if (o == ixp_pkg::OFS_MODE_LAST) begin
          slot0 = SL_MODE;
          if (!mode_ok && (pe == ixp_pkg::ST_OK)) begin
            pe = ixp_pkg::ST_BAD_MODE;
          end
        end
        st_o.pending_error = pe;
        if (o == ixp_pkg::FIXED_LAST) begin
          slot0 = SL_FLAGS;
          if (pe != ixp_pkg::ST_OK) begin
            slot1 = SL_STAT;
            code  = pe;
            st_o.phase = ixp_pkg::PH_DONE;
          end else if (eof) begin
            slot1 = SL_STAT;
            code  = ixp_pkg::ST_UNTERM;
            st_o.phase = ixp_pkg::PH_DONE;
          end else if (ws[11:0] == ixp_pkg::LONG_NAME) begin
            st_o.phase          = ixp_pkg::PH_NLONG;
            st_o.name_remaining = ixp_pkg::LONG_NAME;
          end else if (ws[11:0] == 12'd0) begin
            st_o.phase = ixp_pkg::PH_TERM;
          end else begin
            st_o.phase          = ixp_pkg::PH_NSHORT;
            st_o.name_remaining = ws[11:0];
          end
        end else if (eof) begin
          if (slot0 != SL_NONE) begin
            slot1 = SL_STAT;
          end else begin
            slot0 = SL_STAT;
          end
          code = ixp_pkg::ST_TRUNCATED;
          st_o.phase = ixp_pkg::PH_DONE;
        end else begin
          st_o.field_offset = o + 6'd1;
        end
      end
      ixp_pkg::PH_NSHORT, ixp_pkg::PH_NLONG: begin
        st_o.entry_length_low = ell_inc;
        st_o.name_remaining   = name_dec;
        slot0 = SL_NAME;
        if (eof) begin
          slot1 = SL_STAT;
          code  = ixp_pkg::ST_UNTERM;
          st_o.phase = ixp_pkg::PH_DONE;
        end else if (name_dec == 12'd0) begin
          st_o.phase = (st_i.phase == ixp_pkg::PH_NSHORT) ? ixp_pkg::PH_TERM : ixp_pkg::PH_SCAN;
        end
      end
      ixp_pkg::PH_TERM: begin
        st_o.entry_length_low = ell_inc;
        if (b != 8'd0) begin
          slot0 = SL_STAT;
          code  = ixp_pkg::ST_UNTERM;
          st_o.phase = ixp_pkg::PH_DONE;
        end else begin
          nd = 1'b1;
        end
      end
      ixp_pkg::PH_SCAN: begin
        st_o.entry_length_low = ell_inc;
        if (b == 8'd0) begin
          nd = 1'b1;
        end else begin
          slot0 = SL_NAME;
          if (eof) begin
            slot1 = SL_STAT;
            code  = ixp_pkg::ST_UNTERM;
            st_o.phase = ixp_pkg::PH_DONE;
          end
        end
      end
      ixp_pkg::PH_PAD: begin
        st_o.padding_left = pad_dec;
        if ((pad_dec == 3'd0) || eof) begin
          fin = 1'b1;
        end
      end
      ixp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (nd) begin
      st_o.padding_left = pad_init;
      if ((pad_init == 3'd0) || eof) begin
        fin = 1'b1;
      end else begin
        st_o.phase = ixp_pkg::PH_PAD;
      end
    end

    if (fin) begin
      slot0 = SL_END;
      st_o.entry_index = idx_inc;
      if (idx_inc == st_i.entries_expected) begin
        slot1 = SL_STATN;
        code  = ixp_pkg::ST_OK;
        st_o.phase = ixp_pkg::PH_DONE;
      end else if (eof) begin
        slot1 = SL_STATN;
        code  = ixp_pkg::ST_TRUNCATED;
        st_o.phase = ixp_pkg::PH_DONE;
      end else begin
        st_o.phase            = ixp_pkg::PH_FIXED;
        st_o.field_offset     = 6'd0;
        st_o.entry_length_low = 3'd0;
        st_o.pending_error    = ixp_pkg::ST_OK;
      end
    end
  end

  function automatic ixp_pkg::out_word_t build_res(
    input slot_t       s,
    input logic [31:0] w,
    input logic [7:0]  nb,
    input logic [5:0]  ofs,
    input logic [2:0]  sc,
    input logic [31:0] idx,
    input logic [31:0] idx_next
  );
    ixp_pkg::out_word_t r;
    r = '0;
    r.entry_number = idx;
    unique case (s)
      SL_WORD: begin
        r.out_kind    = ixp_pkg::KIND_FIELD;
        r.field_index = ofs[5:2];
        r.value       = w;
      end
      SL_MODE: begin
        r.out_kind    = ixp_pkg::KIND_FIELD;
        r.field_index = ixp_pkg::FIELD_MODE;
        r.value       = {16'd0, w[15:0]};
        r.mode_class  = w[15:12];
        r.perm_bits   = w[8:0];
      end
      SL_FLAGS: begin
        r.out_kind      = ixp_pkg::KIND_FIELD;
        r.field_index   = ixp_pkg::FIELD_FLAGS;
        r.value         = {16'd0, w[15:0]};
        r.assume_valid  = w[15];
        r.extended_flag = w[14];
        r.stage_num     = w[13:12];
        r.name_len      = w[11:0];
      end
      SL_NAME: begin
        r.out_kind = ixp_pkg::KIND_NAME;
        r.value    = {24'd0, nb};
      end
      SL_END: begin
        r.out_kind = ixp_pkg::KIND_END;
      end
      SL_STAT: begin
        r.out_kind = ixp_pkg::KIND_STATUS;
        r.value    = idx;
        r.status   = sc;
      end
      SL_STATN: begin
        r.out_kind     = ixp_pkg::KIND_STATUS;
        r.value        = idx_next;
        r.entry_number = idx_next;
        r.status       = sc;
      end
      SL_NONE: begin
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // result words
  always_comb begin
    res0_o = build_res(slot0, ws, b, o, code, st_i.entry_index, idx_inc);
    res1_o = build_res(slot1, ws, b, o, code, st_i.entry_index, idx_inc);
    n_res_o = 2'd0;
    if (slot1 != SL_NONE) begin
      res1_o.last_of_run = 1'b1;
      n_res_o = 2'd2;
    end else if (slot0 != SL_NONE) begin
      res0_o.last_of_run = 1'b1;
      n_res_o = 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/index_v2_stream_parser.sv =====
// channel  direction  handshake              word type
// in       input      in_valid / in_stall    ixp_pkg::in_word_t
// out      output     out_valid / out_stall  ixp_pkg::out_word_t
//
// One byte per cycle while in_stall is low; a taken byte waits in the input register, and
// its results then enter the result queue, from which the first leaves while out_stall is low.
// A byte that yields two results holds the output for a second word; a four-word
// result queue absorbs it, and in_stall rises while the input register holds a
// byte and the queue has fewer than two free words.
// Reset is synchronous and clears the parse state and the queue at once.
`default_nettype none

module index_v2_stream_parser (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire ixp_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output ixp_pkg::out_word_t       out_data
);

  logic               v_r;
  logic               v_nxt;
  ixp_pkg::in_word_t  d_r;
  ixp_pkg::state_t    st_r;
  ixp_pkg::state_t    st_nxt;
  ixp_pkg::state_t    st_step;
  ixp_pkg::out_word_t res0;
  ixp_pkg::out_word_t res1;
  logic [1:0]         n_res;

  ixp_pkg::out_word_t q_r [4];
  logic [1:0]         wr_ptr_r;
  logic [1:0]         wr_ptr_nxt;
  logic [1:0]         rd_ptr_r;
  logic [1:0]         rd_ptr_nxt;
  logic [2:0]         cnt_r;
  logic [2:0]         cnt_nxt;
  logic [1:0]         push_cnt;
  logic               pop;
  logic               adv;
  logic               in_take;

  ixp_step u_step (
    .st_i    (st_r),
    .in_i    (d_r),
    .st_o    (st_step),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_res_o (n_res)
  );

  assign adv       = v_r && (cnt_r <= 3'd2);
  assign in_stall  = v_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_cnt  = adv ? n_res : 2'd0;

  always_comb begin
    v_nxt      = in_take ? 1'b1 : (adv ? 1'b0 : v_r);
    st_nxt     = adv ? st_step : st_r;
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= 1'b0;
      st_r     <= '{phase: ixp_pkg::PH_HEADER, default: '0};
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      v_r      <= v_nxt;
      st_r     <= st_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      d_r <= in_data;
    end
    if (push_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ixp_checker.sv =====
`default_nettype none
`include "index_v2_stream_parser_macros.svh"

module ixp_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire ixp_pkg::out_word_t  out_data
);

  logic status_seen_r;
  logic status_seen_nxt;

  assign status_seen_nxt = status_seen_r ||
                           (out_valid && !out_stall &&
                            (out_data.out_kind == ixp_pkg::KIND_STATUS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_seen_r <= 1'b0;
    end else begin
      status_seen_r <= status_seen_nxt;
    end
  end

  `IXP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output word changed")
  `IXP_ASSERT_NOW(a_quiet_after_status, clk, rst_n, status_seen_r, !out_valid, "output word after final status")
  `IXP_ASSERT_NOW(a_status_only_on_status, clk, rst_n, out_valid && (out_data.out_kind != ixp_pkg::KIND_STATUS), out_data.status == ixp_pkg::ST_OK, "status code on a non-status word")
  `IXP_ASSERT_NOW(a_name_byte_clean, clk, rst_n, out_valid && (out_data.out_kind == ixp_pkg::KIND_NAME), (out_data.value[31:8] == 24'd0) && (out_data.field_index == 4'd0), "name byte word carries stray bits")

endmodule

bind index_v2_stream_parser ixp_checker u_ixp_checker (.*);

`default_nettype wire

// ===== verif/index_v2_stream_parser_tb.sv =====
`timescale 1ns / 100ps

module index_v2_stream_parser_tb;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 32;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_t;
  typedef enum {HF_SIG, HF_VERSION, HF_EOF_EARLY, HF_ZERO, HF_EOF_LAST} header_fault_t;
  typedef enum {END_CLEAN, END_CUT, END_UNUSED, END_BAD_MODE, END_BAD_TERM, END_BOTH} file_end_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ixp_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ixp_pkg::out_word_t out_data;

  ixp_pkg::in_word_t  file_bytes[$];
  logic [7:0]         build_buf[$];
  ixp_pkg::out_word_t parsed_words[$];

  logic [31:0] cycles = '0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic        calm;

  ixp_pkg::phase_t ph = ixp_pkg::PH_HEADER;
  logic [3:0]  hdr_ofs = '0;
  logic [5:0]  fix_ofs = '0;
  logic [31:0] shift_reg = '0;
  logic [31:0] entries_total = '0;
  logic [31:0] entries_done = '0;
  logic [11:0] name_left = '0;
  logic [2:0]  len_mod8 = '0;
  logic [2:0]  pad_left = '0;
  logic [2:0]  err_held = '0;

  index_v2_stream_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  assign calm = (cycles[12:11] == 2'b11);

  function automatic ixp_pkg::out_word_t word_of(input logic [1:0] kind,
                                                 input logic [3:0] field,
                                                 input logic [31:0] value);
    ixp_pkg::out_word_t w;
    w = '0;
    w.out_kind = kind;
    w.field_index = field;
    w.value = value;
    w.entry_number = entries_done;
    return w;
  endfunction

  function automatic void send_status(input logic [2:0] code);
    ixp_pkg::out_word_t w;
    w = word_of(ixp_pkg::KIND_STATUS, 4'd0, entries_done);
    w.status = code;
    parsed_words.push_back(w);
    ph = ixp_pkg::PH_DONE;
  endfunction

  function automatic void finish_entry(input logic eof);
    parsed_words.push_back(word_of(ixp_pkg::KIND_END, 4'd0, 32'd0));
    entries_done = entries_done + 32'd1;
    if (entries_done == entries_total) begin
      send_status(ixp_pkg::ST_OK);
    end else if (eof) begin
      send_status(ixp_pkg::ST_TRUNCATED);
    end else begin
      ph = ixp_pkg::PH_FIXED;
      fix_ofs = '0;
      len_mod8 = '0;
      err_held = '0;
    end
  endfunction

  function automatic void name_done(input logic eof);
    pad_left = 3'd0 - len_mod8;
    if (pad_left == 3'd0 || eof) begin
      finish_entry(eof);
    end else begin
      ph = ixp_pkg::PH_PAD;
    end
  endfunction

  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 16);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void buf_word(input logic [31:0] w);
    build_buf.push_back(w[31:24]);
    build_buf.push_back(w[23:16]);
    build_buf.push_back(w[15:8]);
    build_buf.push_back(w[7:0]);
  endfunction

  // move the built bytes out, marking end of file on byte cut and dropping the rest (none if negative)
  function automatic void flush_build(input int cut);
    ixp_pkg::in_word_t w;
    if (cut >= build_buf.size()) cut = build_buf.size() - 1;
    for (int i = 0; i < build_buf.size(); i++) begin
      if (cut >= 0 && i > cut) break;
      w.byte_in = build_buf[i];
      w.end_of_file = (i == cut);
      file_bytes.push_back(w);
    end
    build_buf.delete();
  endfunction

  task automatic add_entry(input fill_t fill, input logic [15:0] unused_w,
                           input logic [15:0] mode_w, input logic [15:0] flags_w,
                           input logic bad_term, input int cut);
    logic [31:0] w;
    int          extra;
    for (int i = 0; i < 14; i++) begin
      case (fill)
        FILL_ONES: w = '1;
        FILL_ZERO: w = '0;
        default:   w = $urandom;
      endcase
      buf_word(w);
      if (i == 5) buf_word({unused_w, mode_w});
    end
    build_buf.push_back(flags_w[15:8]);
    build_buf.push_back(flags_w[7:0]);
    if (flags_w[11:0] == ixp_pkg::LONG_NAME) begin
      extra = $urandom_range(0, 5);
      repeat (ixp_pkg::LONG_NAME) build_buf.push_back(rand_byte());
      repeat (extra) build_buf.push_back(8'($urandom_range(1, 255)));
      build_buf.push_back(8'h00);
    end else begin
      repeat (flags_w[11:0]) build_buf.push_back(rand_byte());
      build_buf.push_back(bad_term ? 8'($urandom_range(1, 255)) : 8'h00);
    end
    repeat ((8 - build_buf.size() % 8) % 8) build_buf.push_back(rand_byte());
    flush_build(cut);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 32'd1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // input driver: advance on acceptance or idle slot
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (file_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= file_bytes.pop_front();
        gap_left <= pick_gap(calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap(calm);
    end
  end

  always @(posedge clk) begin : parse_accepted_byte
    logic [7:0]         b;
    logic               eof;
    logic [31:0]        sig_sh;
    logic [15:0]        half;
    int                 start_n;
    ixp_pkg::out_word_t w;
    if (rst_n && in_valid && !in_stall) begin
      b = in_data.byte_in;
      eof = in_data.end_of_file;
      start_n = parsed_words.size();
      case (ph)
        ixp_pkg::PH_HEADER: begin
          shift_reg = {shift_reg[23:0], b};
          sig_sh = ixp_pkg::SIGNATURE << (8 * hdr_ofs);
          if (hdr_ofs < ixp_pkg::HDR_SIG_LEN && b != sig_sh[31:24]) begin
            send_status(ixp_pkg::ST_BAD_SIG);
          end else begin
            if (hdr_ofs == ixp_pkg::HDR_VERSION_LAST && shift_reg != ixp_pkg::HDR_VERSION)
              err_held = ixp_pkg::ST_BAD_VERSION;
            if (hdr_ofs >= ixp_pkg::HDR_LAST) begin
              if (err_held != 3'd0) begin
                send_status(err_held);
              end else begin
                entries_total = shift_reg;
                if (entries_total == 32'd0) send_status(ixp_pkg::ST_OK);
                else if (eof) send_status(ixp_pkg::ST_TRUNCATED);
                else begin
                  ph = ixp_pkg::PH_FIXED;
                  fix_ofs = '0;
                  len_mod8 = '0;
                end
              end
            end else if (eof) begin
              send_status(ixp_pkg::ST_BAD_SIG);
            end
            hdr_ofs = hdr_ofs + 4'd1;
          end
        end
        ixp_pkg::PH_FIXED: begin
          shift_reg = {shift_reg[23:0], b};
          half = shift_reg[15:0];
          len_mod8 = len_mod8 + 3'd1;
          if (fix_ofs == ixp_pkg::FIXED_LAST) begin
            w = word_of(ixp_pkg::KIND_FIELD, ixp_pkg::FIELD_FLAGS, {16'd0, half});
            w.assume_valid = half[15];
            w.extended_flag = half[14];
            w.stage_num = half[13:12];
            w.name_len = half[11:0];
            parsed_words.push_back(w);
            if (err_held != 3'd0) send_status(err_held);
            else if (eof) send_status(ixp_pkg::ST_UNTERM);
            else if (half[11:0] == ixp_pkg::LONG_NAME) begin
              ph = ixp_pkg::PH_NLONG;
              name_left = ixp_pkg::LONG_NAME;
            end else if (half[11:0] == 12'd0) begin
              ph = ixp_pkg::PH_TERM;
            end else begin
              ph = ixp_pkg::PH_NSHORT;
              name_left = half[11:0];
            end
          end else begin
            if (fix_ofs < ixp_pkg::OFS_WORDS_END && fix_ofs[1:0] == 2'b11) begin
              parsed_words.push_back(word_of(ixp_pkg::KIND_FIELD, fix_ofs[5:2], shift_reg));
            end else if (fix_ofs == ixp_pkg::OFS_UNUSED_LAST) begin
              if (half != 16'd0 && err_held == 3'd0) err_held = ixp_pkg::ST_UNUSED;
            end else if (fix_ofs == ixp_pkg::OFS_MODE_LAST) begin
              w = word_of(ixp_pkg::KIND_FIELD, ixp_pkg::FIELD_MODE, {16'd0, half});
              w.mode_class = half[15:12];
              w.perm_bits = half[8:0];
              parsed_words.push_back(w);
              if (half[15:12] != ixp_pkg::MODE_FILE && half[15:12] != ixp_pkg::MODE_LINK &&
                  half[15:12] != ixp_pkg::MODE_SUBMOD && err_held == 3'd0)
                err_held = ixp_pkg::ST_BAD_MODE;
            end else if (fix_ofs >= ixp_pkg::OFS_IDS_START && fix_ofs < ixp_pkg::OFS_IDS_END &&
                         fix_ofs[1:0] == 2'b11) begin
              parsed_words.push_back(word_of(ixp_pkg::KIND_FIELD, fix_ofs[5:2], shift_reg));
            end
            if (eof) send_status(ixp_pkg::ST_TRUNCATED);
            else fix_ofs = fix_ofs + 6'd1;
          end
        end
        ixp_pkg::PH_NSHORT, ixp_pkg::PH_NLONG: begin
          len_mod8 = len_mod8 + 3'd1;
          parsed_words.push_back(word_of(ixp_pkg::KIND_NAME, 4'd0, {24'd0, b}));
          name_left = name_left - 12'd1;
          if (eof) send_status(ixp_pkg::ST_UNTERM);
          else if (name_left == 12'd0)
            ph = (ph == ixp_pkg::PH_NSHORT) ? ixp_pkg::PH_TERM : ixp_pkg::PH_SCAN;
        end
        ixp_pkg::PH_TERM: begin
          len_mod8 = len_mod8 + 3'd1;
          if (b != 8'd0) send_status(ixp_pkg::ST_UNTERM);
          else name_done(eof);
        end
        ixp_pkg::PH_SCAN: begin
          len_mod8 = len_mod8 + 3'd1;
          if (b == 8'd0) begin
            name_done(eof);
          end else begin
            parsed_words.push_back(word_of(ixp_pkg::KIND_NAME, 4'd0, {24'd0, b}));
            if (eof) send_status(ixp_pkg::ST_UNTERM);
          end
        end
        ixp_pkg::PH_PAD: begin
          pad_left = pad_left - 3'd1;
          if (pad_left == 3'd0 || eof) finish_entry(eof);
        end
        default: ;
      endcase
      if (parsed_words.size() > start_n) begin
        w = parsed_words.pop_back();
        w.last_of_run = 1'b1;
        parsed_words.push_back(w);
      end
    end
  end

  always @(posedge clk) begin : check_output
    ixp_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (parsed_words.size() == 0) begin
        report_mismatch("result with nothing pending, value", out_data.value, '0);
      end else begin
        want = parsed_words.pop_front();
        if (out_data.out_kind !== want.out_kind)
          report_mismatch("out_kind", 32'(out_data.out_kind), 32'(want.out_kind));
        if (out_data.field_index !== want.field_index)
          report_mismatch("field_index", 32'(out_data.field_index), 32'(want.field_index));
        if (out_data.value !== want.value)
          report_mismatch("value", out_data.value, want.value);
        if (out_data.mode_class !== want.mode_class)
          report_mismatch("mode_class", 32'(out_data.mode_class), 32'(want.mode_class));
        if (out_data.perm_bits !== want.perm_bits)
          report_mismatch("perm_bits", 32'(out_data.perm_bits), 32'(want.perm_bits));
        if (out_data.assume_valid !== want.assume_valid)
          report_mismatch("assume_valid", 32'(out_data.assume_valid), 32'(want.assume_valid));
        if (out_data.stage_num !== want.stage_num)
          report_mismatch("stage_num", 32'(out_data.stage_num), 32'(want.stage_num));
        if (out_data.name_len !== want.name_len)
          report_mismatch("name_len", 32'(out_data.name_len), 32'(want.name_len));
        if (out_data.extended_flag !== want.extended_flag)
          report_mismatch("extended_flag", 32'(out_data.extended_flag),
                          32'(want.extended_flag));
        if (out_data.entry_number !== want.entry_number)
          report_mismatch("entry_number", out_data.entry_number, want.entry_number);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  initial begin
    header_fault_t fault;
    file_end_t     ending;
    int            n_entries, long_at, cut, pos;
    logic [31:0]   count, version;
    logic [15:0]   unused_w, mode_w, flags_w;
    logic [11:0]   nlen;
    logic [3:0]    mtype;
    logic          bad_term;
    fill_t         fill;

    if ($urandom_range(0, 9) == 0) begin
      fault = header_fault_t'($urandom_range(0, 4));
      count = (fault == HF_ZERO) ? 32'd0 : $urandom_range(1, 1000);
      version = ixp_pkg::HDR_VERSION;
      if (fault == HF_VERSION || (fault == HF_EOF_EARLY && $urandom_range(0, 1)))
        version = ixp_pkg::HDR_VERSION ^ (32'd1 << $urandom_range(0, 31));
      buf_word(ixp_pkg::SIGNATURE);
      buf_word(version);
      buf_word(count);
      cut = -1;
      case (fault)
        HF_SIG: begin
          pos = $urandom_range(0, 3);
          build_buf[pos] = build_buf[pos] ^ 8'($urandom_range(1, 255));
        end
        HF_EOF_EARLY: cut = $urandom_range(0, 10);
        HF_EOF_LAST:  cut = int'(ixp_pkg::HDR_LAST);
        default: ;
      endcase
      flush_build(cut);
      if (fault == HF_ZERO)
        add_entry(FILL_RANDOM, 16'd0, {ixp_pkg::MODE_FILE, 12'h1A4}, 16'd5, 1'b0, -1);
    end else begin
      ending = file_end_t'($urandom_range(0, 5));
      n_entries = $urandom_range(10, 13);
      count = 32'(n_entries) + ((ending == END_CLEAN) ? 32'd0 : $urandom_range(0, 2));
      buf_word(ixp_pkg::SIGNATURE);
      buf_word(ixp_pkg::HDR_VERSION);
      buf_word(count);
      flush_build(-1);
      long_at = -1;
      if ($urandom_range(0, 7) == 0) long_at = $urandom_range(2, n_entries - 2);
      for (int i = 0; i < n_entries; i++) begin
        fill = (i == 0) ? FILL_ONES : (i == 1) ? FILL_ZERO : FILL_RANDOM;
        case ($urandom_range(0, 2))
          0:       mtype = ixp_pkg::MODE_FILE;
          1:       mtype = ixp_pkg::MODE_LINK;
          default: mtype = ixp_pkg::MODE_SUBMOD;
        endcase
        mode_w = {mtype, 12'($urandom)};
        nlen = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 24)) :
                                               12'($urandom_range(100, 300));
        flags_w = {4'($urandom), nlen};
        unused_w = 16'd0;
        bad_term = 1'b0;
        cut = -1;
        if (i == 0) begin
          mode_w = {ixp_pkg::MODE_SUBMOD, 12'hFFF};
          flags_w = 16'hF007;
        end
        if (i == 1) begin
          mode_w = {ixp_pkg::MODE_LINK, 12'h000};
          flags_w = 16'h0000;
        end
        if (i == long_at) flags_w[11:0] = ixp_pkg::LONG_NAME;
        if (i == n_entries - 1) begin
          do mtype = 4'($urandom_range(0, 15));
          while (mtype == ixp_pkg::MODE_FILE || mtype == ixp_pkg::MODE_LINK ||
                 mtype == ixp_pkg::MODE_SUBMOD);
          if (ending == END_UNUSED || ending == END_BOTH)
            unused_w = 16'($urandom_range(1, 65535));
          if (ending == END_BAD_MODE || ending == END_BOTH)
            mode_w[15:12] = mtype;
          if (ending != END_CLEAN && ending != END_BAD_TERM && $urandom_range(0, 3) == 0)
            cut = int'(ixp_pkg::FIXED_LAST);
          if (ending == END_CUT && cut < 0)
            cut = $urandom_range(0, 70 + flags_w[11:0]);
          if (ending == END_BAD_TERM) bad_term = 1'b1;
        end
        add_entry(fill, unused_w, mode_w, flags_w, bad_term, cut);
      end
    end
    // trailing bytes after the run has ended
    repeat ($urandom_range(4, 12)) begin
      build_buf.push_back(rand_byte());
      flush_build($urandom_range(0, 1) ? 0 : -1);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (file_bytes.size() != 0 || in_valid);
    while (parsed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
